>>> hw/rtl/isd_pkg.sv
// Shared constants, codes and item types for the indent style detector.
package isd_pkg;

    // Block sizing
    localparam int LINE_LIMIT = 5000;
    localparam int MIN_WIDTH  = 2;
    localparam int MAX_WIDTH  = 8;

    localparam int DEPTH_TOP  = 3 * MAX_WIDTH;
    localparam int HIST_SIZE  = DEPTH_TOP + 1;
    localparam int CNT_W      = $clog2(LINE_LIMIT + 1);
    localparam int ADDR_W     = $clog2(HIST_SIZE);
    localparam int WID_W      = $clog2(MAX_WIDTH + 1);
    localparam int RES_W      = $clog2(MAX_WIDTH);

    // Field widths
    localparam int DEPTH_W    = 10;
    localparam int HEAD_W     = 8;
    localparam int KIND_W     = 2;
    localparam int OWID_W     = 4;
    localparam int RATIO_W    = 4;
    localparam int GRACE_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RATIO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRACE = 1'b1;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 4'd4;
    localparam logic [GRACE_W-1:0] GRACE_RESET = 8'd50;

    // Item actions and line head bytes
    localparam logic ACTION_LINE   = 1'b0;
    localparam logic ACTION_FINISH = 1'b1;
    localparam logic [HEAD_W-1:0] HEAD_TAB   = 8'd9;
    localparam logic [HEAD_W-1:0] HEAD_SPACE = 8'd32;

    typedef enum logic [KIND_W-1:0] {
        KIND_INVALID = 2'd0,
        KIND_SPACES  = 2'd1,
        KIND_TABS    = 2'd2
    } t_kind;

    typedef struct packed {
        logic               action;
        logic [DEPTH_W-1:0] indent_depth;
        logic [HEAD_W-1:0]  head_char;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] indent_kind;
        logic [OWID_W-1:0] indent_width;
    } t_out_item;

endpackage

>>> hw/rtl/indent_style_detector.sv
// Indent style detector top level: line counters, depth histogram memory and verdict walk.
//
//   channel   dir  handshake                  payload
//   in        in   i_in_valid / o_in_ready    i_in_item  (t_in_item)
//   out       out  o_out_valid / i_out_ready  o_out_item (t_out_item)
//   cfg       in   i_cfg_we                   i_cfg_idx, i_cfg_data
//
// Line items are taken one per cycle while the detector is idle; the histogram
// read-modify-write runs in the cycle after the accept, with forwarding from the previous write.
// A finish item that is not decided as spaces gives its result in the cycle after the accept.
// A spaces verdict walks the 25-entry histogram through its read port
// and then tries one width per cycle before the result is registered.
// Reset clears the histogram valid bits at once: no clearing pass.
// A finish item waits while an earlier verdict has not been taken; line items do not.
module indent_style_detector
    import isd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_PICK = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [RATIO_W-1:0] r_ratio;
    logic [GRACE_W-1:0] r_grace;

    logic [CNT_W-1:0] r_line_total, r_tab_lines, r_space_lines;

    // Histogram memory and per-entry valid bits
    logic [CNT_W-1:0]     r_hist [HIST_SIZE];
    logic [CNT_W-1:0]     r_rd_data;
    logic [HIST_SIZE-1:0] r_hvld;

    // Line update stage and last-write forwarding
    logic              r_b_vld;
    logic [ADDR_W-1:0] r_b_addr;
    logic              r_lw_vld;
    logic [ADDR_W-1:0] r_lw_addr;
    logic [CNT_W-1:0]  r_lw_data;

    // Histogram walk
    logic              r_iss;
    logic [ADDR_W-1:0] r_addr;
    logic              r_w_vld;
    logic [ADDR_W-1:0] r_w_addr;
    logic [RES_W-1:0]  r_res  [MIN_WIDTH:MAX_WIDTH];
    logic [CNT_W-1:0]  r_miss [MIN_WIDTH:MAX_WIDTH];
    logic              r_occ  [MIN_WIDTH:MAX_WIDTH];

    // Width selection
    logic [WID_W-1:0] r_pick_w, r_best, n_best;

    logic      r_out_vld;
    t_out_item r_out;

    logic in_acc, line_acc, fin_acc, counted, in_bounds, tab_hit, sp_hit;
    logic out_acc, clr, rd_en, walk_last, pick_last, p_take;
    logic [ADDR_W-1:0]        rd_addr;
    logic [CNT_W+RATIO_W-1:0] tab_scaled, sp_scaled;
    t_kind                    fin_kind;
    logic [CNT_W-1:0]         b_old, b_new, w_data, p_miss, bst_miss;
    logic [CNT_W+GRACE_W-1:0] p_prod;

    // Handshakes
    assign o_in_ready = (r_state == S_IDLE) &&
                        !(i_in_valid && (i_in_item.action == ACTION_FINISH) && r_out_vld);
    assign in_acc     = i_in_valid && o_in_ready;
    assign line_acc   = in_acc && (i_in_item.action == ACTION_LINE);
    assign fin_acc    = in_acc && (i_in_item.action == ACTION_FINISH);
    assign out_acc    = r_out_vld && i_out_ready;

    // Line classification
    assign counted   = line_acc && (r_line_total < CNT_W'(LINE_LIMIT));
    assign in_bounds = (i_in_item.indent_depth >= DEPTH_W'(MIN_WIDTH)) &&
                       (i_in_item.indent_depth <= DEPTH_W'(DEPTH_TOP));
    assign tab_hit   = counted && in_bounds && (i_in_item.head_char == HEAD_TAB);
    assign sp_hit    = counted && in_bounds && (i_in_item.head_char == HEAD_SPACE);

    // Kind decision on finish
    assign tab_scaled = r_tab_lines * r_ratio;
    assign sp_scaled  = r_space_lines * r_ratio;
    always_comb begin
        if (r_tab_lines == '0 && r_space_lines == '0) begin
            fin_kind = KIND_INVALID;
        end else if ((CNT_W+RATIO_W)'(r_space_lines) > tab_scaled) begin
            fin_kind = KIND_SPACES;
        end else if ((CNT_W+RATIO_W)'(r_tab_lines) > sp_scaled) begin
            fin_kind = KIND_TABS;
        end else begin
            fin_kind = KIND_INVALID;
        end
    end

    // Histogram increment with forwarding of the last write
    always_comb begin
        if (r_lw_vld && (r_lw_addr == r_b_addr)) begin
            b_old = r_lw_data;
        end else if (r_hvld[r_b_addr]) begin
            b_old = r_rd_data;
        end else begin
            b_old = '0;
        end
    end
    assign b_new = b_old + CNT_W'(1);

    // Walk data: unwritten entries read as zero
    assign w_data    = r_hvld[r_w_addr] ? r_rd_data : '0;
    assign walk_last = r_w_vld && (r_w_addr == ADDR_W'(HIST_SIZE - 1));

    // One width tried per cycle
    assign p_miss    = r_miss[r_pick_w];
    assign bst_miss  = r_miss[r_best];
    assign p_prod    = p_miss * r_grace;
    assign p_take    = r_occ[r_pick_w] &&
                       ((p_miss <= bst_miss) || (p_prod < (CNT_W+GRACE_W)'(r_line_total)));
    assign n_best    = p_take ? r_pick_w : r_best;
    assign pick_last = (r_pick_w == WID_W'(MAX_WIDTH));

    assign clr = (fin_acc && (fin_kind != KIND_SPACES)) ||
                 ((r_state == S_PICK) && pick_last);

    // Memory read port select
    assign rd_en   = sp_hit || ((r_state == S_WALK) && r_iss);
    assign rd_addr = (r_state == S_WALK) ? r_addr : i_in_item.indent_depth[ADDR_W-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (fin_acc && (fin_kind == KIND_SPACES)) n_state = S_WALK;
            end
            S_WALK: begin
                if (walk_last) n_state = S_PICK;
            end
            S_PICK: begin
                if (pick_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Histogram memory
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_hist[rd_addr];
        end
        if (r_b_vld) begin
            r_hist[r_b_addr] <= b_new;
        end
    end

    // Control, counters and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ratio       <= RATIO_RESET;
            r_grace       <= GRACE_RESET;
            r_line_total  <= '0;
            r_tab_lines   <= '0;
            r_space_lines <= '0;
            r_hvld        <= '0;
            r_b_vld       <= 1'b0;
            r_lw_vld      <= 1'b0;
            r_iss         <= 1'b0;
            r_w_vld       <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RATIO: r_ratio <= i_cfg_data[RATIO_W-1:0];
                    REG_GRACE: r_grace <= i_cfg_data[GRACE_W-1:0];
                    default: ;
                endcase
            end

            if (clr) begin
                r_line_total  <= '0;
                r_tab_lines   <= '0;
                r_space_lines <= '0;
            end else begin
                if (counted) r_line_total  <= r_line_total + CNT_W'(1);
                if (tab_hit) r_tab_lines   <= r_tab_lines + CNT_W'(1);
                if (sp_hit)  r_space_lines <= r_space_lines + CNT_W'(1);
            end

            // clear wins over a late write of the finished document
            if (clr) begin
                r_hvld <= '0;
            end else if (r_b_vld) begin
                r_hvld[r_b_addr] <= 1'b1;
            end

            r_b_vld  <= sp_hit;
            r_lw_vld <= r_b_vld && !clr;

            // walk read issue
            if (fin_acc && (fin_kind == KIND_SPACES)) begin
                r_iss <= 1'b1;
            end else if ((r_state == S_WALK) && r_iss &&
                         (r_addr == ADDR_W'(HIST_SIZE - 1))) begin
                r_iss <= 1'b0;
            end
            r_w_vld <= (r_state == S_WALK) && r_iss;

            if (fin_acc && (fin_kind != KIND_SPACES)) begin
                r_out_vld <= 1'b1;
            end else if ((r_state == S_PICK) && pick_last) begin
                r_out_vld <= 1'b1;
            end else if (out_acc) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_b_addr  <= i_in_item.indent_depth[ADDR_W-1:0];
        r_lw_addr <= r_b_addr;
        r_lw_data <= b_new;

        if (fin_acc) begin
            r_addr <= '0;
        end else if ((r_state == S_WALK) && r_iss) begin
            r_addr <= r_addr + ADDR_W'(1);
        end
        r_w_addr <= r_addr;

        // miss counts, occupancy and residues per width
        for (int w = MIN_WIDTH; w <= MAX_WIDTH; w++) begin
            if (fin_acc) begin
                r_res[w]  <= '0;
                r_miss[w] <= '0;
                r_occ[w]  <= 1'b0;
            end else if (r_w_vld) begin
                if (r_res[w] != '0) r_miss[w] <= r_miss[w] + w_data;
                if (r_w_addr == ADDR_W'(w)) r_occ[w] <= (w_data != '0);
                r_res[w] <= (r_res[w] == RES_W'(w - 1)) ? '0 : r_res[w] + RES_W'(1);
            end
        end

        if (walk_last) begin
            r_pick_w <= WID_W'(MIN_WIDTH);
            r_best   <= WID_W'(MIN_WIDTH);
        end else if (r_state == S_PICK) begin
            r_pick_w <= r_pick_w + WID_W'(1);
            r_best   <= n_best;
        end

        if (fin_acc && (fin_kind != KIND_SPACES)) begin
            r_out.indent_kind  <= fin_kind;
            r_out.indent_width <= '0;
        end else if ((r_state == S_PICK) && pick_last) begin
            r_out.indent_kind  <= KIND_SPACES;
            r_out.indent_width <= OWID_W'(n_best);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // Checks
    a_fin_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_acc |=> (r_state == S_WALK) || o_out_valid)
        else $error("finish item neither walked nor answered");

    a_width_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.indent_kind != KIND_SPACES)) |->
            (o_out_item.indent_width == '0))
        else $error("width set on a non-space verdict");

    a_walk_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> !r_b_vld)
        else $error("histogram update pending during walk");

    a_clear_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(clr) |-> (r_hvld == '0))
        else $error("histogram valid bits survive a clear");

    a_walk_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_w_vld |-> $past(r_state == S_WALK))
        else $error("walk data beat outside walk");

endmodule
